// ===== src/ddlt_pkg.sv =====
// ============================================================================
// ddlt_pkg: shared types and constants for the DDL tokenizer
// Kind codes, scan modes, token record and the keyword table.
// ============================================================================
package ddlt_pkg;

    localparam int KeywordLen = 10;
    localparam int LineLen    = 4096;
    localparam int LineCount  = 65536;
    localparam int KwCount    = 21;

    localparam int KindW = 5;
    localparam int LineW = 16;
    localparam int ColW  = 12;
    localparam int ErrW  = 2;
    localparam int KiW   = $clog2(KeywordLen);

    localparam logic [ColW-1:0]  ColMax  = ColW'(LineLen - 1);
    localparam logic [LineW-1:0] LineMax = LineW'(LineCount - 1);

    localparam logic [KindW-1:0] K_EOF    = 5'd0;
    localparam logic [KindW-1:0] K_IDENT  = 5'd1;
    localparam logic [KindW-1:0] K_INT    = 5'd2;
    localparam logic [KindW-1:0] K_FLOAT  = 5'd3;
    localparam logic [KindW-1:0] K_STRING = 5'd4;
    localparam logic [KindW-1:0] K_LPAR   = 5'd5;
    localparam logic [KindW-1:0] K_RPAR   = 5'd6;
    localparam logic [KindW-1:0] K_LBRK   = 5'd7;
    localparam logic [KindW-1:0] K_RBRK   = 5'd8;
    localparam logic [KindW-1:0] K_COMMA  = 5'd9;
    localparam logic [KindW-1:0] K_SEMI   = 5'd10;
    localparam logic [KindW-1:0] K_KW0    = 5'd11;

    localparam logic [ErrW-1:0] E_NONE    = 2'd0;
    localparam logic [ErrW-1:0] E_STRING  = 2'd1;
    localparam logic [ErrW-1:0] E_COMMENT = 2'd2;

    typedef enum logic [9:0] {
        M_IDLE   = 10'b00_0000_0001,
        M_IDENT  = 10'b00_0000_0010,
        M_DASH   = 10'b00_0000_0100,
        M_SLASH  = 10'b00_0000_1000,
        M_INT    = 10'b00_0001_0000,
        M_FRAC   = 10'b00_0010_0000,
        M_STRING = 10'b00_0100_0000,
        M_LINEC  = 10'b00_1000_0000,
        M_BLOCK  = 10'b01_0000_0000,
        M_BSTAR  = 10'b10_0000_0000
    } t_mode;

    // one token result as it travels from scanner to output queue
    typedef struct packed {
        logic [KindW-1:0] kind;
        logic [LineW-1:0] line;
        logic [ColW-1:0]  col;
        logic [ColW-1:0]  len;
        logic [ErrW-1:0]  err;
        logic             last;
    } t_tok;

    // a word is pending for keyword lookup: classified after the pipeline register
    typedef struct packed {
        logic             is_word;
        t_tok             tok;
    } t_slot;

    localparam int TokW = $bits(t_tok);

    typedef logic [KeywordLen*8-1:0] t_word;

    function automatic logic [KeywordLen*8-1:0] kw_text(input int i);
        logic [KeywordLen*8-1:0] t;
        t = '0;
        case (i)
            0:  t[8*2-1:0]  = {"SA"};
            1:  t[8*5-1:0]  = {"KCEHC"};
            2:  t[8*10-1:0] = {"TNIARTSNOC"};
            3:  t[8*6-1:0]  = {"ETAERC"};
            4:  t[8*7-1:0]  = {"TLUAFED"};
            5:  t[8*6-1:0]  = {"ELBUOD"};
            6:  t[8*7-1:0]  = {"NGIEROF"};
            7:  t[8*5-1:0]  = {"TAOLF"};
            8:  t[8*5-1:0]  = {"TNARG"};
            9:  t[8*5-1:0]  = {"23TNI"};
            10: t[8*5-1:0]  = {"46TNI"};
            11: t[8*3-1:0]  = {"YEK"};
            12: t[8*3-1:0]  = {"TON"};
            13: t[8*4-1:0]  = {"LLUN"};
            14: t[8*7-1:0]  = {"YRAMIRP"};
            15: t[8*10-1:0] = {"SECNEREFER"};
            16: t[8*6-1:0]  = {"DEROTS"};
            17: t[8*6-1:0]  = {"GNIRTS"};
            18: t[8*5-1:0]  = {"ELBAT"};
            19: t[8*4-1:0]  = {"EPYT"};
            default: t[8*6-1:0] = {"EUQINU"};
        endcase
        return t;
    endfunction

    function automatic int kw_len(input int i);
        int n;
        case (i)
            0: n = 2;
            1, 7, 8, 9, 10, 18: n = 5;
            2, 15: n = 10;
            3, 5, 16, 17, 20: n = 6;
            4, 6, 14: n = 7;
            11, 12: n = 3;
            default: n = 4;
        endcase
        return n;
    endfunction

    function automatic logic [ColW-1:0] sat_inc(input logic [ColW-1:0] v);
        return (v < ColMax) ? v + 1'b1 : v;
    endfunction

endpackage

// ===== src/ddlt_scan.sv =====
// ============================================================================
// ddlt_scan: character front end
// Tracks position and scan mode, emits up to two token slots per character.
// ============================================================================
module ddlt_scan (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_take,
    input  logic [7:0]              i_ch,
    input  logic                    i_end_of_input,
    output logic                    o_v0,
    output ddlt_pkg::t_slot         o_s0,
    output logic                    o_v1,
    output ddlt_pkg::t_slot         o_s1,
    output ddlt_pkg::t_word         o_word
);
    import ddlt_pkg::*;

    t_mode            r_mode, n_mode;
    logic             r_dq, n_dq;
    logic [7:0]       r_buf [KeywordLen];
    logic [LineW-1:0] r_tline, n_tline, r_line, n_line;
    logic [ColW-1:0]  r_tcol, n_tcol, r_tcnt, n_tcnt, r_col, n_col;
    logic             r_halt, n_halt;
    logic             wr_en;
    logic [KiW-1:0]   wr_idx;
    logic [7:0]       wr_ch;

    logic blank, nl, digit, quote;
    logic [KindW-1:0] pk;
    logic ends_w;

    always_comb begin
        for (int k = 0; k < KeywordLen; k++) o_word[8*k +: 8] = r_buf[k];
    end

    always_comb begin
        blank = (i_ch == 8'd32) || (i_ch == 8'd9) || (i_ch == 8'd11) ||
                (i_ch == 8'd12) || (i_ch == 8'd13);
        nl    = (i_ch == 8'd10);
        digit = (i_ch >= "0") && (i_ch <= "9");
        quote = (i_ch == "'") || (i_ch == "\"");
        case (i_ch)
            "(": pk = K_LPAR;
            ")": pk = K_RPAR;
            "[": pk = K_LBRK;
            "]": pk = K_RBRK;
            ",": pk = K_COMMA;
            ";": pk = K_SEMI;
            default: pk = K_EOF;
        endcase
        ends_w = blank || nl || quote || (i_ch == ".") || (pk != K_EOF);
    end

    always_comb begin
        logic idle_go, wordish;
        t_tok tk;
        n_mode = r_mode; n_dq = r_dq; n_tline = r_tline; n_tcol = r_tcol;
        n_tcnt = r_tcnt; n_line = r_line; n_col = r_col; n_halt = r_halt;
        o_v0 = 1'b0; o_v1 = 1'b0; o_s0 = '0; o_s1 = '0;
        wr_en = 1'b0; wr_idx = '0; wr_ch = i_ch;
        idle_go = 1'b0; wordish = 1'b0;
        tk = '0;
        tk.line = r_tline; tk.col = r_tcol; tk.len = r_tcnt;
        if (i_take && !r_halt) begin
            if (i_end_of_input) begin
                case (r_mode)
                    M_IDENT, M_DASH, M_SLASH: begin
                        tk.kind = K_IDENT; wordish = 1'b1; o_v0 = 1'b1;
                    end
                    M_INT:   begin tk.kind = K_INT;   o_v0 = 1'b1; end
                    M_FRAC:  begin tk.kind = K_FLOAT; o_v0 = 1'b1; end
                    M_STRING: begin
                        tk.kind = K_STRING; tk.err = E_STRING;
                        o_v0 = 1'b1; n_halt = 1'b1;
                    end
                    M_BLOCK, M_BSTAR: begin
                        tk.kind = K_EOF; tk.len = '0; tk.err = E_COMMENT;
                        o_v0 = 1'b1; n_halt = 1'b1;
                    end
                    default: ;
                endcase
                o_s0.tok = tk; o_s0.is_word = wordish;
                if (!n_halt) begin
                    o_v1 = 1'b1;
                    o_s1.tok.kind = K_EOF; o_s1.tok.line = r_line;
                    o_s1.tok.col = r_col;
                end
                n_mode = M_IDLE;
            end else begin
                case (r_mode)
                    M_IDENT, M_DASH, M_SLASH: begin
                        if (r_mode == M_DASH && i_ch == "-") n_mode = M_LINEC;
                        else if (r_mode == M_SLASH && i_ch == "*") n_mode = M_BLOCK;
                        else if (ends_w) begin
                            tk.kind = K_IDENT; wordish = 1'b1; o_v0 = 1'b1;
                            idle_go = 1'b1;
                        end else begin
                            n_mode = M_IDENT;
                            wr_en = r_tcnt < ColW'(KeywordLen);
                            wr_idx = r_tcnt[KiW-1:0];
                            n_tcnt = sat_inc(r_tcnt);
                        end
                    end
                    M_INT: begin
                        if (digit) n_tcnt = sat_inc(r_tcnt);
                        else if (i_ch == ".") begin
                            n_tcnt = sat_inc(r_tcnt); n_mode = M_FRAC;
                        end else begin
                            tk.kind = K_INT; o_v0 = 1'b1; idle_go = 1'b1;
                        end
                    end
                    M_FRAC: begin
                        if (digit) n_tcnt = sat_inc(r_tcnt);
                        else begin
                            tk.kind = K_FLOAT; o_v0 = 1'b1; idle_go = 1'b1;
                        end
                    end
                    M_STRING: begin
                        if (nl) begin
                            tk.kind = K_STRING; tk.err = E_STRING; o_v0 = 1'b1;
                            n_halt = 1'b1; n_mode = M_IDLE;
                        end else if (i_ch == (r_dq ? 8'h22 : 8'h27)) begin
                            tk.kind = K_STRING; o_v0 = 1'b1; n_mode = M_IDLE;
                        end else n_tcnt = sat_inc(r_tcnt);
                    end
                    M_LINEC: if (nl) n_mode = M_IDLE;
                    M_BLOCK: if (i_ch == "*") n_mode = M_BSTAR;
                    M_BSTAR: begin
                        if (i_ch == "/") n_mode = M_IDLE;
                        else if (i_ch != "*") n_mode = M_BLOCK;
                    end
                    default: idle_go = 1'b1;
                endcase
                o_s0.tok = tk; o_s0.is_word = wordish;
                if (idle_go) begin
                    n_mode = M_IDLE;
                    if (blank || nl) ;
                    else if (pk != K_EOF) begin
                        o_v1 = 1'b1;
                        o_s1.tok.kind = pk; o_s1.tok.line = r_line;
                        o_s1.tok.col = r_col; o_s1.tok.len = ColW'(1);
                    end else begin
                        n_tline = r_line; n_tcol = r_col;
                        if (quote) begin
                            n_mode = M_STRING; n_dq = (i_ch == "\""); n_tcnt = '0;
                        end else if (digit || i_ch == ".") begin
                            n_mode = digit ? M_INT : M_FRAC; n_tcnt = ColW'(1);
                        end else begin
                            n_mode = (i_ch == "-") ? M_DASH :
                                     (i_ch == "/") ? M_SLASH : M_IDENT;
                            wr_en = 1'b1; wr_idx = '0; n_tcnt = ColW'(1);
                        end
                    end
                end
                if (nl) begin
                    if (r_line < LineMax) n_line = r_line + 1'b1;
                    n_col = '0;
                end else n_col = sat_inc(r_col);
            end
        end
        // a single result always sits in slot 0
        if (!o_v0 && o_v1) begin
            o_v0 = 1'b1; o_s0 = o_s1; o_v1 = 1'b0;
        end
        if (o_v1) o_s1.tok.last = 1'b1;
        else o_s0.tok.last = o_v0;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) r_buf[wr_idx] <= wr_ch;
        r_tline <= n_tline; r_tcol <= n_tcol; r_tcnt <= n_tcnt; r_dq <= n_dq;
        if (!i_rst_n) begin
            r_mode <= M_IDLE; r_line <= '0; r_col <= '0; r_halt <= 1'b0;
        end else begin
            r_mode <= n_mode; r_line <= n_line; r_col <= n_col; r_halt <= n_halt;
        end
    end

endmodule

// ===== src/ddlt_kw.sv =====
// ============================================================================
// ddlt_kw: keyword lookup
// Resolves the kind of a word token against the keyword list.
// ============================================================================
module ddlt_kw (
    input  ddlt_pkg::t_slot  i_slot,
    input  ddlt_pkg::t_word  i_word,
    output ddlt_pkg::t_tok   o_tok
);
    import ddlt_pkg::*;

    always_comb begin
        logic [KindW-1:0] k;
        logic             hit;
        k = K_IDENT; hit = 1'b0;
        for (int i = 0; i < KwCount; i++) begin
            if (!hit && i_slot.tok.len == ColW'(kw_len(i)) &&
                (i_word & ((t_word'(1) << (8*kw_len(i))) - 1'b1)) == kw_text(i)) begin
                hit = 1'b1;
                k = K_KW0 + KindW'(i);
            end
        end
        o_tok = i_slot.tok;
        if (i_slot.is_word) o_tok.kind = k;
    end

endmodule

// ===== src/ddlt_fifo.sv =====
// ============================================================================
// ddlt_fifo: result queue
// Four-entry queue taking up to two tokens per cycle, delivering one.
// ============================================================================
module ddlt_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_w0,
    input  ddlt_pkg::t_tok     i_d0,
    input  logic               i_w1,
    input  ddlt_pkg::t_tok     i_d1,
    input  logic               i_pop,
    output logic               o_empty,
    output logic               o_room2,
    output ddlt_pkg::t_tok     o_head
);
    import ddlt_pkg::*;

    t_tok       r_mem [4];
    logic [1:0] r_rd, r_wr;
    logic [2:0] r_cnt, n_cnt;
    logic       pop_ok;

    assign o_empty = (r_cnt == 3'd0);
    // room for two more after this cycle's writes, pops not counted
    assign o_room2 = ((r_cnt + 3'(i_w0) + 3'(i_w1)) <= 3'd2);
    assign o_head  = r_mem[r_rd];
    assign pop_ok  = i_pop && !o_empty;

    always_comb begin
        n_cnt = r_cnt + 3'(i_w0) + 3'(i_w1) - 3'(pop_ok);
    end

    always_ff @(posedge i_clk) begin
        if (i_w0) r_mem[r_wr] <= i_d0;
        if (i_w1) r_mem[r_wr + 2'd1] <= i_d1;
        if (!i_rst_n) begin
            r_rd <= '0; r_wr <= '0; r_cnt <= '0;
        end else begin
            r_rd  <= r_rd + 2'(pop_ok);
            r_wr  <= r_wr + 2'(i_w0) + 2'(i_w1);
            r_cnt <= n_cnt;
        end
    end

endmodule

// ===== src/ddl_tokenizer_unit.sv =====
// ============================================================================
// ddl_tokenizer_unit: streaming SQL DDL lexer
// One character per transfer in, token records out through a small queue.
// ============================================================================
// Throughput: one character per cycle while the queue, counting the staged
//   pair about to be written, keeps room for two more tokens.
// Token path: the character ending a token passes the scan register stage,
//   the keyword lookup stage, then the queue, whose head drives the outputs.
// Reset: synchronous, active low; clears mode, position, halt and queues.
//   The identifier buffer is not cleared.
module ddl_tokenizer_unit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic [7:0]                i_ch,
    input  logic                      i_end_of_input,
    output logic                      empty,
    input  logic                      pop,
    output logic [ddlt_pkg::KindW-1:0] o_kind,
    output logic [ddlt_pkg::LineW-1:0] o_start_line,
    output logic [ddlt_pkg::ColW-1:0]  o_start_column,
    output logic [ddlt_pkg::ColW-1:0]  o_token_length,
    output logic [ddlt_pkg::ErrW-1:0]  o_error,
    output logic                      o_last
);
    import ddlt_pkg::*;

    logic   take, v0, v1, room2;
    t_slot  s0, s1;
    t_word  word;
    // pipeline register between scanner and keyword lookup
    logic   r_v0, r_v1;
    t_slot  r_s0, r_s1;
    t_word  r_word;
    t_tok   k0, head;

    // stall input unless the queue, with the staged pair written, keeps room for two
    assign full = !room2;
    assign take = push && !full;

    ddlt_scan u_scan (
        .i_clk, .i_rst_n, .i_take(take), .i_ch, .i_end_of_input,
        .o_v0(v0), .o_s0(s0), .o_v1(v1), .o_s1(s1), .o_word(word)
    );

    // the word buffer is captured with the slot; words always sit in slot 0
    always_ff @(posedge i_clk) begin
        r_s0 <= s0; r_s1 <= s1; r_word <= word;
        if (!i_rst_n) begin
            r_v0 <= 1'b0; r_v1 <= 1'b0;
        end else begin
            r_v0 <= v0; r_v1 <= v1;
        end
    end

    ddlt_kw u_kw (.i_slot(r_s0), .i_word(r_word), .o_tok(k0));

    ddlt_fifo u_fifo (
        .i_clk, .i_rst_n,
        .i_w0(r_v0), .i_d0(k0), .i_w1(r_v1), .i_d1(r_s1.tok),
        .i_pop(pop), .o_empty(empty), .o_room2(room2), .o_head(head)
    );

    assign o_kind         = head.kind;
    assign o_start_line   = head.line;
    assign o_start_column = head.col;
    assign o_token_length = head.len;
    assign o_error        = head.err;
    assign o_last         = head.last;

endmodule

// ===== src/ddlt_checker.sv =====
// ============================================================================
// ddlt_checker: port-level checks for the tokenizer
// ============================================================================
module ddlt_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        push,
    input logic                        full,
    input logic                        empty,
    input logic                        pop,
    input logic [ddlt_pkg::KindW-1:0]  o_kind,
    input logic [ddlt_pkg::ErrW-1:0]   o_error
);
    import ddlt_pkg::*;

    a_err_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_error == E_NONE || o_error == E_STRING || o_error == E_COMMENT))
        else $error("bad error code");
    a_cmt_eof: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_error == E_COMMENT) |-> o_kind == K_EOF) else $error("comment err kind");
    a_str_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_error == E_STRING) |-> o_kind == K_STRING) else $error("string err kind");
    a_rst_empty: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> empty) else $error("queue not empty after reset");
endmodule

bind ddl_tokenizer_unit ddlt_checker u_chk (
    .i_clk, .i_rst_n, .push, .full, .empty, .pop, .o_kind, .o_error
);

// ===== tb/tb_ddl_tokenizer_unit.sv =====
// ============================================================================
// tb_ddl_tokenizer_unit: self-checking bench for the DDL tokenizer
// Feeds character streams through the push/full side, predicts token records
// with a behavioral lexer and checks every popped record in order.
// ============================================================================
`timescale 1ns / 1ps

module tb_ddl_tokenizer_unit;
    import ddlt_pkg::*;

    // lexer states of the behavioral predictor
    typedef enum int {
        S_IDLE, S_IDENT, S_DASH, S_SLASH, S_INT, S_FRAC, S_STRING, S_LINEC, S_BLOCK, S_BSTAR
    } t_scan;

    typedef struct packed {
        logic [7:0] ch;
        logic       eoi;
    } t_char;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic push = 1'b0;
    logic pop = 1'b0;
    logic [7:0] i_ch = '0;
    logic i_end_of_input = 1'b0;
    logic full, empty;
    logic [KindW-1:0] o_kind;
    logic [LineW-1:0] o_start_line;
    logic [ColW-1:0] o_start_column, o_token_length;
    logic [ErrW-1:0] o_error;
    logic o_last;

    ddl_tokenizer_unit u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full),
        .i_ch(i_ch), .i_end_of_input(i_end_of_input), .empty(empty), .pop(pop),
        .o_kind(o_kind), .o_start_line(o_start_line), .o_start_column(o_start_column),
        .o_token_length(o_token_length), .o_error(o_error), .o_last(o_last)
    );

    always #4 i_clk = ~i_clk;

    t_char char_queue[$];   // characters waiting to be pushed
    t_tok  token_queue[$];  // token records the lexer model expects
    int    mismatch_count = 0;
    bit    stim_done = 1'b0;

    // ---------------- lexer model state ----------------
    t_scan      lx_mode = S_IDLE;
    bit         lx_dq = 1'b0;
    byte        lx_buf[KeywordLen];
    int         lx_tline = 0, lx_tcol = 0, lx_tcnt = 0;
    int         lx_line = 0, lx_col = 0;
    bit         lx_halt = 1'b0;
    t_tok       step_toks[$];

    function automatic int len_up(input int v);
        return (v < LineLen - 1) ? v + 1 : v;
    endfunction

    function automatic bit is_blank(input byte unsigned c);
        return c == 32 || c == 9 || c == 11 || c == 12 || c == 13;
    endfunction

    function automatic logic [KindW-1:0] punct_of(input byte unsigned c);
        case (c)
            "(": return K_LPAR;
            ")": return K_RPAR;
            "[": return K_LBRK;
            "]": return K_RBRK;
            ",": return K_COMMA;
            ";": return K_SEMI;
            default: return K_EOF;
        endcase
    endfunction

    function automatic bit is_digit(input byte unsigned c);
        return c >= "0" && c <= "9";
    endfunction

    task automatic add_tok(input logic [KindW-1:0] k, input int ln, input int cl,
                           input int len, input logic [ErrW-1:0] e);
        t_tok t;
        t.kind = k; t.line = ln[LineW-1:0]; t.col = cl[ColW-1:0];
        t.len = len[ColW-1:0]; t.err = e; t.last = 1'b0;
        step_toks.push_back(t);
    endtask

    task automatic begin_tok(input t_scan m);
        lx_mode = m; lx_tline = lx_line; lx_tcol = lx_col; lx_tcnt = 0;
    endtask

    task automatic buf_add(input byte unsigned c);
        if (lx_tcnt < KeywordLen) lx_buf[lx_tcnt] = c;
        lx_tcnt = len_up(lx_tcnt);
    endtask

    // keyword lookup spelled out in reading order
    task automatic emit_word();
        string kws[21] = '{"AS", "CHECK", "CONSTRAINT", "CREATE", "DEFAULT", "DOUBLE",
            "FOREIGN", "FLOAT", "GRANT", "INT32", "INT64", "KEY", "NOT", "NULL", "PRIMARY",
            "REFERENCES", "STORED", "STRING", "TABLE", "TYPE", "UNIQUE"};
        logic [KindW-1:0] k;
        bit hit;
        k = K_IDENT;
        for (int i = 0; i < 21; i++) begin
            if (kws[i].len() == lx_tcnt && lx_tcnt <= KeywordLen && k == K_IDENT) begin
                hit = 1'b1;
                for (int j = 0; j < lx_tcnt; j++)
                    if (kws[i][j] != lx_buf[j]) hit = 1'b0;
                if (hit) k = K_KW0 + KindW'(i);
            end
        end
        add_tok(k, lx_tline, lx_tcol, lx_tcnt, E_NONE);
        lx_mode = S_IDLE;
    endtask

    task automatic idle_ch(input byte unsigned c);
        logic [KindW-1:0] p;
        p = punct_of(c);
        if (is_blank(c) || c == 10) return;
        if (p != K_EOF) begin
            add_tok(p, lx_line, lx_col, 1, E_NONE);
        end else if (c == "-") begin
            begin_tok(S_DASH); buf_add(c);
        end else if (c == "/") begin
            begin_tok(S_SLASH); buf_add(c);
        end else if (c == "'" || c == "\"") begin
            begin_tok(S_STRING); lx_dq = (c == "\"");
        end else if (is_digit(c)) begin
            begin_tok(S_INT); lx_tcnt = 1;
        end else if (c == ".") begin
            begin_tok(S_FRAC); lx_tcnt = 1;
        end else begin
            begin_tok(S_IDENT); buf_add(c);
        end
    endtask

    task automatic ident_ch(input byte unsigned c);
        if (is_blank(c) || c == 10 || c == "'" || c == "\"" || c == "." ||
            punct_of(c) != K_EOF) begin
            emit_word(); idle_ch(c);
        end else begin
            buf_add(c);
        end
    endtask

    // one accepted character: appends its records to token_queue
    task automatic predict_tokens(input t_char it);
        byte unsigned c;
        c = it.ch;
        step_toks.delete();
        if (lx_halt) return;
        if (it.eoi) begin
            case (lx_mode)
                S_IDENT, S_DASH, S_SLASH: emit_word();
                S_INT: add_tok(K_INT, lx_tline, lx_tcol, lx_tcnt, E_NONE);
                S_FRAC: add_tok(K_FLOAT, lx_tline, lx_tcol, lx_tcnt, E_NONE);
                S_STRING: begin
                    add_tok(K_STRING, lx_tline, lx_tcol, lx_tcnt, E_STRING); lx_halt = 1'b1;
                end
                S_BLOCK, S_BSTAR: begin
                    add_tok(K_EOF, lx_tline, lx_tcol, 0, E_COMMENT); lx_halt = 1'b1;
                end
                default: ;
            endcase
            if (!lx_halt) add_tok(K_EOF, lx_line, lx_col, 0, E_NONE);
            lx_mode = S_IDLE;
        end else begin
            case (lx_mode)
                S_IDENT: ident_ch(c);
                S_DASH: if (c == "-") lx_mode = S_LINEC;
                        else begin lx_mode = S_IDENT; ident_ch(c); end
                S_SLASH: if (c == "*") lx_mode = S_BLOCK;
                         else begin lx_mode = S_IDENT; ident_ch(c); end
                S_INT: begin
                    if (is_digit(c)) lx_tcnt = len_up(lx_tcnt);
                    else if (c == ".") begin lx_tcnt = len_up(lx_tcnt); lx_mode = S_FRAC; end
                    else begin
                        add_tok(K_INT, lx_tline, lx_tcol, lx_tcnt, E_NONE);
                        lx_mode = S_IDLE; idle_ch(c);
                    end
                end
                S_FRAC: begin
                    if (is_digit(c)) lx_tcnt = len_up(lx_tcnt);
                    else begin
                        add_tok(K_FLOAT, lx_tline, lx_tcol, lx_tcnt, E_NONE);
                        lx_mode = S_IDLE; idle_ch(c);
                    end
                end
                S_STRING: begin
                    if (c == 10) begin
                        add_tok(K_STRING, lx_tline, lx_tcol, lx_tcnt, E_STRING);
                        lx_halt = 1'b1; lx_mode = S_IDLE;
                    end else if (c == (lx_dq ? "\"" : "'")) begin
                        add_tok(K_STRING, lx_tline, lx_tcol, lx_tcnt, E_NONE);
                        lx_mode = S_IDLE;
                    end else lx_tcnt = len_up(lx_tcnt);
                end
                S_LINEC: if (c == 10) lx_mode = S_IDLE;
                S_BLOCK: if (c == "*") lx_mode = S_BSTAR;
                S_BSTAR: if (c == "/") lx_mode = S_IDLE;
                         else if (c != "*") lx_mode = S_BLOCK;
                default: begin lx_mode = S_IDLE; idle_ch(c); end
            endcase
            if (c == 10) begin
                if (lx_line < LineCount - 1) lx_line++;
                lx_col = 0;
            end else lx_col = len_up(lx_col);
        end
        for (int i = 0; i < step_toks.size(); i++) begin
            t_tok t;
            t = step_toks[i];
            t.last = (i == step_toks.size() - 1);
            token_queue.push_back(t);
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // ---------------- stimulus generation ----------------
    task automatic add_text(input string s);
        t_char t;
        for (int i = 0; i < s.len(); i++) begin
            t.ch = s[i]; t.eoi = 1'b0; char_queue.push_back(t);
        end
    endtask

    task automatic add_eoi(input logic [7:0] junk);
        t_char t;
        t.ch = junk; t.eoi = 1'b1; char_queue.push_back(t);
    endtask

    function automatic string rand_word();
        string kws[21] = '{"AS", "CHECK", "CONSTRAINT", "CREATE", "DEFAULT", "DOUBLE",
            "FOREIGN", "FLOAT", "GRANT", "INT32", "INT64", "KEY", "NOT", "NULL", "PRIMARY",
            "REFERENCES", "STORED", "STRING", "TABLE", "TYPE", "UNIQUE"};
        string s;
        int n;
        if ($urandom_range(0, 1)) begin
            s = kws[$urandom_range(0, 20)];
            // occasionally near-miss a keyword
            if ($urandom_range(0, 5) == 0) s = {s, "X"};
            if ($urandom_range(0, 7) == 0) s = s.tolower();
            return s;
        end
        n = $urandom_range(1, 14);
        s = "";
        for (int i = 0; i < n; i++)
            s = {s, string'(byte'(i == 0 ? $urandom_range(65, 90) : $urandom_range(48, 122)))};
        return s;
    endfunction

    function automatic string rand_digits(input int n);
        string s;
        s = "";
        for (int i = 0; i < n; i++) s = {s, string'(byte'($urandom_range(48, 57)))};
        return s;
    endfunction

    // one lexeme with its trailing separator; separators are sometimes omitted
    task automatic add_piece();
        string seps[9] = '{" ", "\n", "(", ")", "[", "]", ",", ";", "\t"};
        string q;
        t_char t;
        case ($urandom_range(0, 11))
            0, 1, 2: add_text(rand_word());
            3: add_text(rand_digits($urandom_range(1, 6)));
            4: add_text({rand_digits($urandom_range(0, 3)), ".", rand_digits($urandom_range(0, 3))});
            5: begin
                q = $urandom_range(0, 1) ? "'" : "\"";
                add_text({q, rand_word(), " ", rand_word(), q});
            end
            6: add_text({"-- ", rand_word(), " ", rand_word(), "\n"});
            7: add_text({"/* ", rand_word(), "\n*", rand_word(), " **/"});
            8: add_text($urandom_range(0, 1) ? "-x" : "/y");
            9: begin
                t.ch = 8'($urandom_range(0, 255)); t.eoi = 1'b0; char_queue.push_back(t);
            end
            default: ;
        endcase
        if ($urandom_range(0, 4) != 0) add_text(seps[$urandom_range(0, 8)]);
    endtask

    // ---------------- driver ----------------
    int    push_gap = 0;
    int    pop_gap = 0;
    int    acc_count = 0;   // transfers seen at rising edges
    int    acc_seen = 0;    // transfers already retired by the driver
    bit    took = 1'b0;
    t_char cur_item;

    // input transfers are taken at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && push && !full) begin
            predict_tokens(cur_item);
            void'(char_queue.pop_front());
            acc_count++;
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            took = (acc_count != acc_seen);
            acc_seen = acc_count;
            if (took) push_gap = gap_len();
            if (push && !took) begin
                // hold the pending transfer
            end else if (char_queue.size() > 0 && push_gap == 0) begin
                cur_item = char_queue[0];
                push <= 1'b1;
                i_ch <= cur_item.ch;
                i_end_of_input <= cur_item.eoi;
            end else begin
                if (push_gap > 0) push_gap--;
                push <= 1'b0;
                i_ch <= 8'($urandom_range(0, 255));
                i_end_of_input <= 1'b0;
            end
            if (pop_gap > 0) begin
                pop <= 1'b0;
                pop_gap--;
            end else begin
                pop <= 1'b1;
                pop_gap = gap_len();
            end
        end
    end

    // ---------------- monitor ----------------
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (token_queue.size() == 0) begin
                report_mismatch("unexpected record, kind", o_kind, -1);
            end else begin
                t_tok w;
                w = token_queue.pop_front();
                if (o_kind !== w.kind) report_mismatch("kind", o_kind, w.kind);
                if (o_start_line !== w.line) report_mismatch("line", o_start_line, w.line);
                if (o_start_column !== w.col) report_mismatch("column", o_start_column, w.col);
                if (o_token_length !== w.len) report_mismatch("length", o_token_length, w.len);
                if (o_error !== w.err) report_mismatch("error", o_error, w.err);
                if (o_last !== w.last) report_mismatch("last", o_last, w.last);
            end
        end
    end

    // ---------------- main sequence ----------------
    initial begin
        string long_id;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // directed: every punctuation, keywords, numbers, comments and edge cases
        add_text("CREATE TABLE t(a INT32,b[1]);\n");
        add_text("CONSTRAINT REFERENCESX create .5 12.34 7. 'it' \"q'x\"");
        add_text("-a /b --c\n/*/ x */z");
        add_eoi(8'hFF);
        // words longer than the keyword buffer and a long number
        long_id = "";
        for (int i = 0; i < 14; i++) long_id = {long_id, "w"};
        add_text({long_id, " CONSTRAINTS ", rand_digits(12), " x\n"});
        add_eoi(8'h00);
        // random tail sized to the item budget
        while (char_queue.size() < 1650) begin
            for (int j = 0; j < 10; j++) add_piece();
            if ($urandom_range(0, 3) == 0) add_eoi(8'($urandom_range(0, 255)));
        end
        add_eoi(8'h5A);
        // unterminated block comment halts; further input is ignored
        add_text("x /* never closed");
        add_eoi(8'h00);
        add_text("CREATE");
        add_eoi(8'h00);
        wait (char_queue.size() == 0 && !push);
        wait (token_queue.size() == 0);
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0 && token_queue.size() == 0) begin
            $display("PASS ddl_tokenizer_unit");
        end else begin
            $display("FAIL ddl_tokenizer_unit");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("FAIL ddl_tokenizer_unit");
        $finish;
    end

endmodule
